// ----- sv/integer_binary_alu_with_gcd_unit_defines.svh -----
// Assertion macros for the integer ALU with gcd.
`ifndef INTEGER_BINARY_ALU_WITH_GCD_UNIT_DEFINES_SVH
`define INTEGER_BINARY_ALU_WITH_GCD_UNIT_DEFINES_SVH
`ifndef SYNTH
`define ALU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ALU_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ALU_ASSERT(label, clk, rst_n, prop)
`define ALU_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ----- sv/ibalu_pkg.sv -----
// Package: payload types, command codes, controller types.
`timescale 1ns / 1ps
package ibalu_pkg;
    localparam int FieldWidth = 32;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_MUL  = 4'd2,
        CMD_AND  = 4'd3,
        CMD_XOR  = 4'd4,
        CMD_OR   = 4'd5,
        CMD_SHL  = 4'd6,
        CMD_SAR  = 4'd7,
        CMD_REM  = 4'd8,
        CMD_QUOT = 4'd9,
        CMD_GCD  = 4'd10,
        CMD_MIN  = 4'd11,
        CMD_MAX  = 4'd12
    } cmd_t;

    typedef struct packed {
        logic [3:0]                   command;
        logic signed [FieldWidth-1:0] operand_a;
        logic signed [FieldWidth-1:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic signed [FieldWidth-1:0] result_value;
        logic                         status;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FAST,
        ST_DIV,
        ST_GCD,
        ST_FIX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;      // capture operands
        logic fast;      // compute add/sub/mul/logic/shift/min/max
        logic div_step;  // one restoring-divide step
        logic gcd_step;  // one remainder-gcd step
        logic gcd_init;  // start next gcd remainder
        logic fix;       // apply sign / gcd result
        logic out_load;  // move result to output register
    } ctrl_t;

    typedef struct packed {
        logic is_div;
        logic is_gcd;
        logic div_zero;
        logic div_last;
        logic gcd_done;
    } stat_t;
endpackage

// ----- sv/ibalu_datapath.sv -----
// Datapath: operand registers, combinational ALU, shared iterative divider.
`timescale 1ns / 1ps
`include "integer_binary_alu_with_gcd_unit_defines.svh"
module ibalu_datapath #(
    parameter int WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ibalu_pkg::in_item_t  in_item,
    input  ibalu_pkg::ctrl_t     ctrl,
    output ibalu_pkg::stat_t     stat,
    output ibalu_pkg::out_item_t out_item
);
    localparam int CntW = $clog2(WIDTH);
    localparam int FW   = ibalu_pkg::FieldWidth;

    logic [3:0]       cmd_reg;
    logic [WIDTH-1:0] a_reg, b_reg;
    logic [WIDTH-1:0] q_reg, q_next;     // dividend shifting into quotient
    logic [WIDTH:0]   r_reg, r_next;     // partial remainder
    logic [WIDTH-1:0] d_reg, d_next;     // divisor
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic [WIDTH-1:0] res_reg, res_next;
    logic             st_reg, st_next;
    logic             out_st_reg;
    logic [FW-1:0]    out_val_reg;

    logic [WIDTH-1:0] in_a, in_b, mag_a, mag_b, fast_res;
    logic [WIDTH:0]   r_shift, r_sub;
    logic             a_neg, b_neg, amt_ok;
    logic [WIDTH-1:0] sar_fill;

    assign in_a  = WIDTH'(in_item.operand_a);
    assign in_b  = WIDTH'(in_item.operand_b);
    assign a_neg = a_reg[WIDTH-1];
    assign b_neg = b_reg[WIDTH-1];
    // magnitudes of the incoming operands, loaded into the divider at accept
    assign mag_a = in_a[WIDTH-1] ? (~in_a + 1'b1) : in_a;
    assign mag_b = in_b[WIDTH-1] ? (~in_b + 1'b1) : in_b;
    assign amt_ok = !b_neg && (b_reg < WIDTH'(WIDTH));
    assign sar_fill = {WIDTH{a_neg}};

    always_comb begin
        case (cmd_reg)
            ibalu_pkg::CMD_ADD: fast_res = a_reg + b_reg;
            ibalu_pkg::CMD_SUB: fast_res = a_reg - b_reg;
            ibalu_pkg::CMD_MUL: fast_res = WIDTH'(a_reg * b_reg);
            ibalu_pkg::CMD_AND: fast_res = a_reg & b_reg;
            ibalu_pkg::CMD_XOR: fast_res = a_reg ^ b_reg;
            ibalu_pkg::CMD_OR:  fast_res = a_reg | b_reg;
            ibalu_pkg::CMD_SHL: fast_res = amt_ok ? (a_reg << b_reg[CntW-1:0]) : '0;
            ibalu_pkg::CMD_SAR:
                fast_res = amt_ok ? WIDTH'($signed(a_reg) >>> b_reg[CntW-1:0]) : sar_fill;
            ibalu_pkg::CMD_MIN:
                fast_res = ($signed(a_reg) < $signed(b_reg)) ? a_reg : b_reg;
            ibalu_pkg::CMD_MAX:
                fast_res = ($signed(b_reg) < $signed(a_reg)) ? a_reg : b_reg;
            default: fast_res = '0;
        endcase
    end

    // restoring division step, shared by rem, quot and gcd
    assign r_shift = {r_reg[WIDTH-1:0], q_reg[WIDTH-1]};
    assign r_sub   = r_shift - {1'b0, d_reg};

    always_comb begin
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        st_next  = st_reg;
        if (ctrl.fast) begin
            res_next = fast_res;
            st_next  = 1'b0;
        end
        if (ctrl.div_step || ctrl.gcd_step) begin
            if (!r_sub[WIDTH]) begin
                r_next = r_sub;
                q_next = {q_reg[WIDTH-2:0], 1'b1};
            end else begin
                r_next = r_shift;
                q_next = {q_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
        if (ctrl.load) begin
            // gcd: x in res_reg, y in d_reg; divide x by y
            q_next   = mag_a;
            r_next   = '0;
            d_next   = mag_b;
            cnt_next = CntW'(WIDTH - 1);
            res_next = mag_a;
            st_next  = 1'b0;
        end
        if (ctrl.gcd_init) begin
            // x <- y, y <- x mod y
            res_next = d_reg;
            q_next   = d_reg;
            d_next   = r_reg[WIDTH-1:0];
            r_next   = '0;
            cnt_next = CntW'(WIDTH - 1);
        end
        if (ctrl.fix) begin
            if (cmd_reg == ibalu_pkg::CMD_GCD) begin
                res_next = res_reg;
            end else if (d_reg == '0) begin
                res_next = '0;
                st_next  = 1'b1;
            end else if (cmd_reg == ibalu_pkg::CMD_REM) begin
                res_next = a_neg ? (~r_reg[WIDTH-1:0] + 1'b1) : r_reg[WIDTH-1:0];
            end else begin
                res_next = (a_neg != b_neg) ? (~q_reg + 1'b1) : q_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg <= in_item.command;
            a_reg   <= in_a;
            b_reg   <= in_b;
        end
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
        st_reg  <= st_next;
        if (ctrl.out_load) begin
            out_val_reg <= FW'(res_reg);
            out_st_reg  <= st_reg;
        end
    end

    // all status below comes from registers (d_reg also changes per gcd round, cnt_reg
    // per divide step); the controller first decodes it in ST_FAST, in the cycle after load
    assign stat.is_div   = (cmd_reg == ibalu_pkg::CMD_REM) || (cmd_reg == ibalu_pkg::CMD_QUOT);
    assign stat.is_gcd   = (cmd_reg == ibalu_pkg::CMD_GCD);
    assign stat.div_zero = (d_reg == '0);
    assign stat.div_last = (cnt_reg == '0);
    assign stat.gcd_done = (d_reg == '0);

    assign out_item.result_value = out_val_reg;
    assign out_item.status       = out_st_reg;

    `ALU_ASSERT(a_status_only_div, aclk, aresetn,
        ctrl.out_load && st_reg |-> stat.is_div)
    `ALU_ASSERT(a_step_exclusive, aclk, aresetn,
        !(ctrl.div_step && ctrl.gcd_init))
    `ALU_ASSERT(a_load_alone, aclk, aresetn,
        ctrl.load |-> !ctrl.fix && !ctrl.out_load)
endmodule

// ----- sv/ibalu_ctrl.sv -----
// Controller state machine: sequences load, division steps, gcd rounds, output.
`timescale 1ns / 1ps
`include "integer_binary_alu_with_gcd_unit_defines.svh"
module ibalu_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  ibalu_pkg::stat_t stat,
    output ibalu_pkg::ctrl_t ctrl
);
    ibalu_pkg::state_t state_reg, state_next;
    logic              mv_reg, mv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ibalu_pkg::ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_ready    = 1'b0;
        mv_next    = mv_reg && !m_ready;
        case (state_reg)
            ibalu_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.load  = 1'b1;
                    state_next = ibalu_pkg::ST_FAST;
                end
            end
            ibalu_pkg::ST_FAST: begin
                // operands now in registers; the divider was loaded at accept
                ctrl.load = 1'b0;
                if (stat.is_gcd) begin
                    state_next = stat.gcd_done ? ibalu_pkg::ST_OUT : ibalu_pkg::ST_GCD;
                end else if (stat.is_div) begin
                    state_next = stat.div_zero ? ibalu_pkg::ST_FIX : ibalu_pkg::ST_DIV;
                end else begin
                    ctrl.fast  = 1'b1;
                    state_next = ibalu_pkg::ST_OUT;
                end
            end
            ibalu_pkg::ST_DIV: begin
                ctrl.div_step = 1'b1;
                if (stat.div_last) state_next = ibalu_pkg::ST_FIX;
            end
            ibalu_pkg::ST_GCD: begin
                ctrl.gcd_step = 1'b1;
                if (stat.div_last) state_next = ibalu_pkg::ST_FIX;
            end
            ibalu_pkg::ST_FIX: begin
                if (stat.is_gcd) begin
                    ctrl.gcd_init = 1'b1;
                    state_next    = ibalu_pkg::ST_FAST;
                end else begin
                    ctrl.fix   = 1'b1;
                    state_next = ibalu_pkg::ST_OUT;
                end
            end
            ibalu_pkg::ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    ctrl.out_load = 1'b1;
                    mv_next       = 1'b1;
                    state_next    = ibalu_pkg::ST_IDLE;
                end
            end
            default: state_next = ibalu_pkg::ST_IDLE;
        endcase
    end

    assign m_valid = mv_reg;

    `ALU_ASSERT(a_out_no_overwrite, aclk, aresetn,
        m_valid && !m_ready |=> m_valid)
    `ALU_ASSERT(a_ready_idle_only, aclk, aresetn,
        s_ready |-> state_reg == ibalu_pkg::ST_IDLE)
    `ALU_ASSERT(a_accept_starts, aclk, aresetn,
        s_valid && s_ready |=> state_reg == ibalu_pkg::ST_FAST)
endmodule

// ----- sv/integer_binary_alu_with_gcd_unit.sv -----
// Top level: integer ALU with iterative divide and gcd.
// Add/sub/mul/logic/shift/min/max pass through the accept, compute and output states.
// Rem/quot run one divide step per quotient bit, then a sign fix; zero divisors skip them.
// Gcd runs one remainder division per Euclid round, at most about 1.5*WIDTH rounds.
// One transaction in flight; the next is accepted when the result is registered.
// Reset (aresetn, synchronous, active low) clears the controller and output valid.
`timescale 1ns / 1ps
module integer_binary_alu_with_gcd_unit #(
    parameter int WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ibalu_pkg::in_item_t  s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ibalu_pkg::out_item_t m_payload
);
    ibalu_pkg::ctrl_t ctrl;
    ibalu_pkg::stat_t stat;
    ibalu_pkg::in_item_t held;

    // the datapath captures operands and divider start values at the
    // accepting edge; the payload is not used after that
    assign held = s_payload;

    ibalu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    ibalu_datapath #(.WIDTH(WIDTH)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (held),
        .ctrl     (ctrl),
        .stat     (stat),
        .out_item (m_payload)
    );
endmodule

// ----- tb/integer_binary_alu_with_gcd_unit_checker.sv -----
// Checker: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps
module integer_binary_alu_with_gcd_unit_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  ibalu_pkg::in_item_t  s_payload,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  ibalu_pkg::out_item_t m_payload,
    output int                   error_count,
    output int                   pending_count
);
    localparam int W = ibalu_pkg::FieldWidth;

    ibalu_pkg::out_item_t expected_results[$];

    function automatic logic [W-1:0] mag(logic [W-1:0] v);
        return v[W-1] ? -v : v;
    endfunction

    function automatic ibalu_pkg::out_item_t alu_predict(ibalu_pkg::in_item_t t);
        ibalu_pkg::out_item_t r;
        logic [W-1:0]         a, b, x, y, tmp;
        a = t.operand_a;
        b = t.operand_b;
        r.result_value = '0;
        r.status = 1'b0;
        case (t.command)
            ibalu_pkg::CMD_ADD: r.result_value = a + b;
            ibalu_pkg::CMD_SUB: r.result_value = a - b;
            ibalu_pkg::CMD_MUL: r.result_value = a * b;
            ibalu_pkg::CMD_AND: r.result_value = a & b;
            ibalu_pkg::CMD_XOR: r.result_value = a ^ b;
            ibalu_pkg::CMD_OR:  r.result_value = a | b;
            ibalu_pkg::CMD_SHL: r.result_value = (b[W-1] || b >= W) ? '0 : a << b;
            ibalu_pkg::CMD_SAR: r.result_value = (b[W-1] || b >= W) ? {W{a[W-1]}}
                                                        : W'($signed(a) >>> b);
            ibalu_pkg::CMD_REM, ibalu_pkg::CMD_QUOT: begin
                if (b == 0) begin
                    r.status = 1'b1;
                end else if (t.command == ibalu_pkg::CMD_REM) begin
                    tmp = mag(a) % mag(b);
                    r.result_value = a[W-1] ? -tmp : tmp;
                end else begin
                    tmp = mag(a) / mag(b);
                    r.result_value = (a[W-1] != b[W-1]) ? -tmp : tmp;
                end
            end
            ibalu_pkg::CMD_GCD: begin
                x = mag(a);
                y = mag(b);
                while (y != 0) begin
                    tmp = x % y;
                    x = y;
                    y = tmp;
                end
                r.result_value = x;
            end
            ibalu_pkg::CMD_MIN: r.result_value = ($signed(a) < $signed(b)) ? a : b;
            ibalu_pkg::CMD_MAX: r.result_value = ($signed(b) < $signed(a)) ? a : b;
            default: r.result_value = '0;
        endcase
        return r;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge aclk) begin
        ibalu_pkg::out_item_t want;
        if (!aresetn) begin
            error_count <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(alu_predict(s_payload));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    error_count <= error_count + 1;
                    if (error_count < 10)
                        $display("unexpected result transaction: %0d/%0b",
                                 m_payload.result_value, m_payload.status);
                end else begin
                    want = expected_results.pop_front();
                    if (want.result_value !== m_payload.result_value ||
                        want.status !== m_payload.status) begin
                        error_count <= error_count + 1;
                        if (error_count < 10)
                            $display("mismatch: expected %0d/%0b, got %0d/%0b",
                                     want.result_value, want.status,
                                     m_payload.result_value, m_payload.status);
                    end
                end
            end
        end
    end
endmodule

// ----- tb/integer_binary_alu_with_gcd_unit_test.sv -----
// Testbench top: clock, reset, stimulus with idling phases, and the verdict.
`timescale 1ns / 1ps
module integer_binary_alu_with_gcd_unit_test;
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7fff_ffff;
    localparam logic [31:0] MINUS_ONE = 32'hffff_ffff;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    ibalu_pkg::in_item_t  s_payload = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    ibalu_pkg::out_item_t m_payload;
    int                   error_count;
    int                   pending_count;
    int                   send_idle_pct = 0;   // chance per cycle the sender holds back
    int                   recv_stall_pct = 0;  // chance per cycle the receiver stalls

    integer_binary_alu_with_gcd_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    integer_binary_alu_with_gcd_unit_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .error_count(error_count), .pending_count(pending_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver: ready is redrawn every cycle from the current stall chance.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Drive one transaction: optional idle cycles first, then hold until taken.
    // Valid drops only in idle cycles, so each edge sees one assignment.
    task automatic send_op(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= {cmd, a, b};
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Operand mix: edge values often, small values for shifts/divides, else full range.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5, 0))
            0: case ($urandom_range(4, 0))
                0: return MOST_NEG;
                1: return MOST_POS;
                2: return MINUS_ONE;
                3: return 32'd0;
                default: return 32'd1;
            endcase
            1: return $urandom_range(40, 0);
            2: return -$urandom_range(40, 1);
            3: return $urandom_range(100000, 0) * (1 << $urandom_range(8, 0));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        logic [3:0] cmd;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            // mostly real opcodes, a few unused codes
            cmd = ($urandom_range(19, 0) == 0)
                ? 4'($urandom_range(15, 13))
                : 4'($urandom_range(ibalu_pkg::CMD_MAX, ibalu_pkg::CMD_ADD));
            send_op(cmd, pick_operand(), pick_operand());
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every opcode, field extremes, the named corner cases.
        send_op(ibalu_pkg::CMD_ADD,  MOST_POS, 32'd1);
        send_op(ibalu_pkg::CMD_SUB,  MOST_NEG, 32'd1);
        send_op(ibalu_pkg::CMD_MUL,  MOST_NEG, MINUS_ONE);
        send_op(ibalu_pkg::CMD_AND,  32'hf0f0_a5a5, MINUS_ONE);
        send_op(ibalu_pkg::CMD_XOR,  32'h5555_aaaa, 32'hffff_0000);
        send_op(ibalu_pkg::CMD_OR,   32'h1234_0000, 32'h0000_8765);
        send_op(ibalu_pkg::CMD_SHL,  32'h8000_0001, 32'd31);
        send_op(ibalu_pkg::CMD_SHL,  MINUS_ONE, 32'd32);
        send_op(ibalu_pkg::CMD_SHL,  MINUS_ONE, MINUS_ONE);
        send_op(ibalu_pkg::CMD_SAR,  MOST_NEG, 32'd31);
        send_op(ibalu_pkg::CMD_SAR,  MOST_NEG, MOST_NEG);
        send_op(ibalu_pkg::CMD_SAR,  MOST_POS, 32'd40);
        send_op(ibalu_pkg::CMD_REM,  32'd7, 32'd0);
        send_op(ibalu_pkg::CMD_QUOT, MOST_NEG, 32'd0);
        send_op(ibalu_pkg::CMD_QUOT, MOST_NEG, MINUS_ONE);
        send_op(ibalu_pkg::CMD_REM,  MOST_NEG, MINUS_ONE);
        send_op(ibalu_pkg::CMD_REM,  -32'sd7, 32'd2);
        send_op(ibalu_pkg::CMD_QUOT, 32'd7, -32'sd2);
        send_op(ibalu_pkg::CMD_GCD,  32'd0, 32'd0);
        send_op(ibalu_pkg::CMD_GCD,  MOST_NEG, 32'd0);
        send_op(ibalu_pkg::CMD_GCD,  MOST_POS, 32'h7fff_fffe);
        send_op(ibalu_pkg::CMD_MIN,  MOST_NEG, MOST_POS);
        send_op(ibalu_pkg::CMD_MAX,  MOST_NEG, MOST_POS);
        send_op(4'd13, MINUS_ONE, MINUS_ONE);
        send_op(4'd15, MOST_NEG, MOST_POS);

        random_phase(200, 0, 0);
        random_phase(200, 65, 0);
        random_phase(200, 0, 65);
        random_phase(200, 25, 25);
        s_valid <= 1'b0;

        recv_stall_pct = 0;
        while (pending_count != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (error_count == 0 && pending_count == 0)
            $display("integer_binary_alu_with_gcd_unit test passed");
        else
            $display("integer_binary_alu_with_gcd_unit test failed");
        $finish;
    end

    // Watchdog: 825 items, gcd ones up to about 1.5*WIDTH Euclid rounds each, plus stalls; ample margin.
    initial begin
        #200ms;
        $display("integer_binary_alu_with_gcd_unit test failed");
        $finish;
    end
endmodule
